// ===== rtl/radtxt_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix text package
// Shared constants, types and helper functions for the signed integer to
// custom radix text converter.
// ----------------------------------------------------------------------------
package radtxt_pkg;

  // Width of the signed input number.
  localparam int VALUE_BITS  = 32;
  // Largest alphabet that may be configured.
  localparam int MAX_SYMBOLS = 16;

  localparam int CHAR_BITS   = 8;
  localparam int DIGIT_BITS  = 4;
  localparam int RADIX_BITS  = 5;
  localparam int CFG_BITS    = 64;
  localparam int CFG_IDX_BITS = 2;
  localparam int ALPHA_BITS  = 2 * CFG_BITS;
  // Digit stack index and digit count (the count must also hold VALUE_BITS).
  localparam int INDEX_BITS  = $clog2(VALUE_BITS);
  localparam int COUNT_BITS  = $clog2(VALUE_BITS + 1);
  localparam int PROD_BITS   = 2 * VALUE_BITS;

  localparam logic [CHAR_BITS-1:0] SIGN_CHAR = 8'h2D;
  localparam logic [CHAR_BITS-1:0] PLUS_CHAR = 8'h2B;
  localparam logic [RADIX_BITS-1:0] MIN_RADIX = RADIX_BITS'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ALPHABET_LOW  = 2'd0,
    REG_ALPHABET_HIGH = 2'd1,
    REG_RADIX         = 2'd2
  } cfg_reg_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Reciprocals floor(2^VALUE_BITS / k) for the supported bases. The entries
  // for zero and one are never used, as such alphabets are rejected.
  localparam logic [VALUE_BITS:0] RECIP_NUM = {1'b1, {VALUE_BITS{1'b0}}};
  localparam logic [VALUE_BITS-1:0] RECIP_TABLE [0:16] = '{
    {VALUE_BITS{1'b1}},
    {VALUE_BITS{1'b1}},
    VALUE_BITS'(RECIP_NUM / 2),
    VALUE_BITS'(RECIP_NUM / 3),
    VALUE_BITS'(RECIP_NUM / 4),
    VALUE_BITS'(RECIP_NUM / 5),
    VALUE_BITS'(RECIP_NUM / 6),
    VALUE_BITS'(RECIP_NUM / 7),
    VALUE_BITS'(RECIP_NUM / 8),
    VALUE_BITS'(RECIP_NUM / 9),
    VALUE_BITS'(RECIP_NUM / 10),
    VALUE_BITS'(RECIP_NUM / 11),
    VALUE_BITS'(RECIP_NUM / 12),
    VALUE_BITS'(RECIP_NUM / 13),
    VALUE_BITS'(RECIP_NUM / 14),
    VALUE_BITS'(RECIP_NUM / 15),
    VALUE_BITS'(RECIP_NUM / 16)
  };

  // Picks one symbol byte out of the packed alphabet.
  function automatic logic [CHAR_BITS-1:0] symbol_at(
    input logic [ALPHA_BITS-1:0] alphabet,
    input logic [DIGIT_BITS-1:0] idx
  );
    symbol_at = alphabet[idx*CHAR_BITS +: CHAR_BITS];
  endfunction

endpackage

// ===== rtl/signed_int_to_custom_radix_text.sv =====
// ----------------------------------------------------------------------------
// Signed integer to custom radix text
// Converts a signed 32-bit number to text in a configured base, using a
// configured alphabet, one character per output transfer.
// ----------------------------------------------------------------------------
// Usage.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the two alphabet words and the radix; cfg_ready is always high, writes are
// to be made only while the converter is idle, and higher indexes are ignored.
// The input channel transfers one number when in_valid is high and in_stall is
// low; in_stall stays high while a number is converted. With an unusable
// alphabet (radix below two or above sixteen, a repeated symbol, or a sign
// among the symbols in use) the number is consumed and gives no output.
// The output channel transfers one character when out_valid is high and
// out_stall is low: a minus sign for a negative number, then the digits most
// significant first, with final_char set on the last one.
// A number gives one to thirty-two digits. Each digit is found in a multiply
// state and then a correct-and-push state; a negative number then has its
// sign loaded into the output register, and the digits follow one at a time,
// most significant first. The next number is taken only once the last digit
// has been loaded. A stalled receiver holds the output register and pauses
// emission. Reset clears the control and configuration registers, but not the
// reciprocal, the product, the digit stack or the output payload.
// ----------------------------------------------------------------------------
module signed_int_to_custom_radix_text (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [radtxt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [radtxt_pkg::CFG_BITS-1:0]          cfg_data,
  // Number input channel.
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [radtxt_pkg::VALUE_BITS-1:0] value,
  // Character output channel.
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [radtxt_pkg::CHAR_BITS-1:0]         character,
  output logic                                     final_char
);

  // Configuration registers.
  logic [radtxt_pkg::CFG_BITS-1:0]   alphabet_low;
  logic [radtxt_pkg::CFG_BITS-1:0]   alphabet_high;
  logic [radtxt_pkg::RADIX_BITS-1:0] radix;
  logic [radtxt_pkg::ALPHA_BITS-1:0] alphabet;

  // Conversion state.
  radtxt_pkg::state_t state;
  radtxt_pkg::state_t state_next;
  logic [radtxt_pkg::VALUE_BITS-1:0] magnitude;
  logic [radtxt_pkg::VALUE_BITS-1:0] recip;
  logic [radtxt_pkg::PROD_BITS-1:0]  product;
  logic [radtxt_pkg::COUNT_BITS-1:0] digit_count;
  logic                              is_negative;
  logic [radtxt_pkg::DIGIT_BITS-1:0] digit_stack [radtxt_pkg::VALUE_BITS];

  logic alphabet_ok;
  logic in_xfer;
  logic out_free;
  logic done_dividing;

  // Divide step signals.
  logic [radtxt_pkg::VALUE_BITS-1:0] quot_est;
  logic [radtxt_pkg::VALUE_BITS-1:0] quot_times_radix;
  logic [radtxt_pkg::VALUE_BITS-1:0] rem_est;
  logic [radtxt_pkg::VALUE_BITS-1:0] radix_wide;
  logic [radtxt_pkg::VALUE_BITS-1:0] quot_fix;
  logic [radtxt_pkg::VALUE_BITS-1:0] rem_fix;
  logic [radtxt_pkg::COUNT_BITS-1:0] count_inc;

  // Emission signals.
  logic [radtxt_pkg::COUNT_BITS-1:0] top_pos;
  logic [radtxt_pkg::DIGIT_BITS-1:0] top_digit;

  logic [radtxt_pkg::VALUE_BITS-1:0] raw;
  logic [radtxt_pkg::VALUE_BITS-1:0] raw_mag;

  assign alphabet  = {alphabet_high, alphabet_low};
  assign cfg_ready = 1'b1;

  // The alphabet check looks at every symbol pair in parallel; symbols at or
  // above the radix are ignored.
  always_comb begin
    alphabet_ok = (radix >= radtxt_pkg::MIN_RADIX) &&
                  (radix <= radtxt_pkg::RADIX_BITS'(radtxt_pkg::MAX_SYMBOLS));
    for (int a = 0; a < radtxt_pkg::MAX_SYMBOLS; a++) begin
      if (radtxt_pkg::RADIX_BITS'(a) < radix) begin
        if (radtxt_pkg::symbol_at(alphabet, radtxt_pkg::DIGIT_BITS'(a)) ==
              radtxt_pkg::SIGN_CHAR ||
            radtxt_pkg::symbol_at(alphabet, radtxt_pkg::DIGIT_BITS'(a)) ==
              radtxt_pkg::PLUS_CHAR) begin
          alphabet_ok = 1'b0;
        end
        for (int b = a + 1; b < radtxt_pkg::MAX_SYMBOLS; b++) begin
          if (radtxt_pkg::RADIX_BITS'(b) < radix &&
              radtxt_pkg::symbol_at(alphabet, radtxt_pkg::DIGIT_BITS'(a)) ==
              radtxt_pkg::symbol_at(alphabet, radtxt_pkg::DIGIT_BITS'(b))) begin
            alphabet_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_stall = (state != radtxt_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // The output register may be loaded when it is empty or being emptied.
  assign out_free = !out_valid || !out_stall;

  // The magnitude is taken as unsigned, so the most negative number is exact.
  assign raw     = $unsigned(value);
  assign raw_mag = raw[radtxt_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Correction step: the reciprocal estimate is the true quotient or one
  // below it, so a single compare and subtract finishes the division.
  assign radix_wide       = radtxt_pkg::VALUE_BITS'(radix);
  assign quot_est         = product[radtxt_pkg::PROD_BITS-1 -: radtxt_pkg::VALUE_BITS];
  assign quot_times_radix = quot_est * radix_wide;
  assign rem_est          = magnitude - quot_times_radix;
  always_comb begin
    if (rem_est >= radix_wide) begin
      quot_fix = quot_est + 1'b1;
      rem_fix  = rem_est - radix_wide;
    end else begin
      quot_fix = quot_est;
      rem_fix  = rem_est;
    end
  end
  assign count_inc     = digit_count + 1'b1;
  assign done_dividing = (quot_fix == '0) ||
                         (count_inc == radtxt_pkg::COUNT_BITS'(radtxt_pkg::VALUE_BITS));

  assign top_pos   = digit_count - 1'b1;
  assign top_digit = digit_stack[top_pos[radtxt_pkg::INDEX_BITS-1:0]];

  always_comb begin
    state_next = state;
    case (state)
      radtxt_pkg::ST_IDLE: begin
        if (in_xfer && alphabet_ok) state_next = radtxt_pkg::ST_MUL;
      end
      radtxt_pkg::ST_MUL: begin
        state_next = radtxt_pkg::ST_FIX;
      end
      radtxt_pkg::ST_FIX: begin
        if (!done_dividing) state_next = radtxt_pkg::ST_MUL;
        else if (is_negative) state_next = radtxt_pkg::ST_SIGN;
        else state_next = radtxt_pkg::ST_EMIT;
      end
      radtxt_pkg::ST_SIGN: begin
        if (out_free) state_next = radtxt_pkg::ST_EMIT;
      end
      radtxt_pkg::ST_EMIT: begin
        if (out_free && digit_count == radtxt_pkg::COUNT_BITS'(1)) begin
          state_next = radtxt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = radtxt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= radtxt_pkg::ST_IDLE;
      alphabet_low  <= '0;
      alphabet_high <= '0;
      radix         <= '0;
      digit_count   <= '0;
      is_negative   <= 1'b0;
      magnitude     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          radtxt_pkg::REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
          radtxt_pkg::REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
          radtxt_pkg::REG_RADIX:         radix <= cfg_data[radtxt_pkg::RADIX_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (state == radtxt_pkg::ST_IDLE && in_xfer) begin
        is_negative <= raw[radtxt_pkg::VALUE_BITS-1];
        magnitude   <= raw_mag;
        digit_count <= '0;
      end
      if (state == radtxt_pkg::ST_FIX) begin
        magnitude   <= quot_fix;
        digit_count <= count_inc;
      end
      if (state == radtxt_pkg::ST_EMIT && out_free) begin
        digit_count <= top_pos;
      end
      // Output register: loaded by the sign and digit states, emptied by a
      // transfer to the receiver.
      if ((state == radtxt_pkg::ST_SIGN || state == radtxt_pkg::ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == radtxt_pkg::ST_IDLE && in_xfer) begin
      recip <= radtxt_pkg::RECIP_TABLE[radix];
    end
    if (state == radtxt_pkg::ST_MUL) begin
      product <= magnitude * recip;
    end
    if (state == radtxt_pkg::ST_FIX) begin
      digit_stack[digit_count[radtxt_pkg::INDEX_BITS-1:0]] <=
        rem_fix[radtxt_pkg::DIGIT_BITS-1:0];
    end
    if (state == radtxt_pkg::ST_SIGN && out_free) begin
      character  <= radtxt_pkg::SIGN_CHAR;
      final_char <= 1'b0;
    end
    if (state == radtxt_pkg::ST_EMIT && out_free) begin
      character  <= radtxt_pkg::symbol_at(alphabet, top_digit);
      final_char <= (digit_count == radtxt_pkg::COUNT_BITS'(1));
    end
  end

  // Checks on the sequencer and the divide unit.
  a_reject_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !alphabet_ok) |=> (state == radtxt_pkg::ST_IDLE))
    else $error("rejected alphabet still started a conversion");

  a_fix_radix_valid: assert property (@(posedge clk) disable iff (rst)
    (state == radtxt_pkg::ST_FIX) |-> (radix >= radtxt_pkg::MIN_RADIX))
    else $error("divide step running with an unusable radix");

  a_remainder_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == radtxt_pkg::ST_FIX) |-> (rem_fix < radix_wide))
    else $error("reciprocal estimate needed more than one correction");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == radtxt_pkg::ST_EMIT) |-> (digit_count != '0))
    else $error("emission entered with an empty digit stack");

  a_fix_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == radtxt_pkg::ST_FIX) |->
      (digit_count < radtxt_pkg::COUNT_BITS'(radtxt_pkg::VALUE_BITS)))
    else $error("digit stack overflow");

endmodule

// ===== bench/tb_signed_int_to_custom_radix_text.sv =====
// ----------------------------------------------------------------------------
// Testbench for the signed integer to custom radix text converter
// Drives numbers and alphabet settings into the converter, predicts the text
// that each accepted number must produce, and checks every output transfer
// against that prediction, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_signed_int_to_custom_radix_text;

  timeunit 1ns;
  timeprecision 1ps;

  // A base-two number of the largest magnitude keeps the sequencer busy
  // longest. This stretch of quiet is allowed before any register is
  // rewritten.
  localparam int IDLE_SETTLE = 128;

  // Index values above the radix register are accepted by the block and have
  // no effect; this is the one spare index.
  localparam logic [radtxt_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic [radtxt_pkg::VALUE_BITS-1:0] MOST_NEGATIVE =
    {1'b1, {(radtxt_pkg::VALUE_BITS-1){1'b0}}};
  localparam logic [radtxt_pkg::VALUE_BITS-1:0] MOST_POSITIVE =
    {1'b0, {(radtxt_pkg::VALUE_BITS-1){1'b1}}};

  // Plain ASCII alphabets: digits then upper case letters.
  localparam logic [radtxt_pkg::CFG_BITS-1:0] DIGITS_LOW  = 64'h3736353433323130;
  localparam logic [radtxt_pkg::CFG_BITS-1:0] DIGITS_HIGH = 64'h4645444342413938;

  // One expected character of a number's text.
  typedef struct packed {
    logic [radtxt_pkg::CHAR_BITS-1:0] code;
    logic                             last;
  } text_char_t;

  logic                                     clk = 1'b0;
  logic                                     rst = 1'b1;
  logic                                     cfg_valid = 1'b0;
  logic                                     cfg_ready;
  logic [radtxt_pkg::CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [radtxt_pkg::CFG_BITS-1:0]          cfg_data = '0;
  logic                                     in_valid = 1'b0;
  logic                                     in_stall;
  logic signed [radtxt_pkg::VALUE_BITS-1:0] value = '0;
  logic                                     out_valid;
  logic                                     out_stall = 1'b0;
  logic [radtxt_pkg::CHAR_BITS-1:0]         character;
  logic                                     final_char;

  // Copy of the configuration as the block should hold it.
  logic [radtxt_pkg::CFG_BITS-1:0]   alpha_low_cfg  = '0;
  logic [radtxt_pkg::CFG_BITS-1:0]   alpha_high_cfg = '0;
  logic [radtxt_pkg::RADIX_BITS-1:0] radix_cfg      = '0;

  // Characters predicted but not yet seen on the output, oldest first.
  text_char_t pending_text[$];
  int         mismatch_count = 0;

  // Sender burst control.
  bit gaps_on = 1'b1;
  int burst_left = 0;

  // Receiver control: a rotating stall pattern, and a long hold-off that the
  // receiver process counts down itself once it has been requested.
  bit          stall_on = 1'b1;
  logic [15:0] stall_pattern = '0;
  int          pattern_age = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  signed_int_to_custom_radix_text i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .final_char (final_char)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Symbol byte k of the configured alphabet.
  function automatic logic [radtxt_pkg::CHAR_BITS-1:0] alphabet_symbol(
    input int unsigned k
  );
    logic [radtxt_pkg::ALPHA_BITS-1:0] word;
    word = {alpha_high_cfg, alpha_low_cfg} >> (k * radtxt_pkg::CHAR_BITS);
    return word[radtxt_pkg::CHAR_BITS-1:0];
  endfunction

  // The block refuses to convert with a radix outside two to sixteen, with a
  // repeated symbol among those in use, or with a sign among them. Bytes
  // beyond the radix do not matter at all.
  function automatic bit alphabet_usable();
    logic [radtxt_pkg::CHAR_BITS-1:0] sym;
    if (radix_cfg < radtxt_pkg::MIN_RADIX ||
        radix_cfg > radtxt_pkg::RADIX_BITS'(radtxt_pkg::MAX_SYMBOLS)) return 1'b0;
    for (int a = 0; a < radix_cfg; a++) begin
      sym = alphabet_symbol(a);
      if (sym == radtxt_pkg::SIGN_CHAR || sym == radtxt_pkg::PLUS_CHAR) return 1'b0;
      for (int b = a + 1; b < radix_cfg; b++) begin
        if (alphabet_symbol(b) == sym) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Appends the text of one accepted number to the pending queue. The
  // magnitude is negated in unsigned arithmetic, so the most negative number
  // comes out as exactly two to the thirty-first.
  function automatic void predict_text(input logic [radtxt_pkg::VALUE_BITS-1:0] raw);
    logic [radtxt_pkg::VALUE_BITS-1:0] magnitude;
    logic [radtxt_pkg::DIGIT_BITS-1:0] digits[radtxt_pkg::VALUE_BITS];
    int                                count;
    if (!alphabet_usable()) return;
    magnitude = raw[radtxt_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    count = 0;
    do begin
      digits[count] = radtxt_pkg::DIGIT_BITS'(magnitude % radix_cfg);
      magnitude     = magnitude / radix_cfg;
      count++;
    end while (magnitude != 0 && count < radtxt_pkg::VALUE_BITS);
    if (raw[radtxt_pkg::VALUE_BITS-1]) begin
      pending_text.push_back(text_char_t'{code: radtxt_pkg::SIGN_CHAR, last: 1'b0});
    end
    for (int k = count; k > 0; k--) begin
      pending_text.push_back(text_char_t'{code: alphabet_symbol(digits[k-1]),
                                          last: (k == 1)});
    end
  endfunction

  // ------------------------------------------------------------------------
  // Output checking: every character transfer is compared with the oldest
  // expected character, both the byte and the end-of-text flag.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, character, final_char);
        mismatch_count++;
      end else begin
        want = pending_text.pop_front();
        if (character !== want.code || final_char !== want.last) begin
          $display("%0t: character mismatch, expected %h last %b, actual %h last %b",
                   $time, want.code, want.last, character, final_char);
          mismatch_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver. A requested hold-off takes priority; otherwise, when stalling
  // is enabled, a 16-bit pattern is rotated and replaced now and then. A
  // pattern always keeps at least one free slot, and one in four is all free.
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        if ($urandom_range(0, 3) == 0) stall_pattern = '0;
        else stall_pattern = 16'($urandom()) & ~(16'h1 << $urandom_range(0, 15));
        pattern_age = $urandom_range(16, 96);
      end
      pattern_age--;
      out_stall     <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // ------------------------------------------------------------------------
  // Shared driving tasks. Each is entered just after a falling edge and
  // returns just after a falling edge.
  // ------------------------------------------------------------------------

  // Offers one number and waits for its transfer. The sender works in bursts;
  // between bursts, when gaps are on, valid drops for a random stretch.
  task automatic send_number(input logic [radtxt_pkg::VALUE_BITS-1:0] number);
    if (burst_left <= 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    value    <= number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text(number);
    burst_left--;
    @(negedge clk);
  endtask

  // Holds the sender back until every expected character has come out.
  task automatic wait_text_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_text.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // As above, then a stretch of quiet before the configuration is touched.
  task automatic wait_idle();
    wait_text_drained();
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [radtxt_pkg::CFG_IDX_BITS-1:0] index,
                           input logic [radtxt_pkg::CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      radtxt_pkg::REG_ALPHABET_LOW:  alpha_low_cfg  = data;
      radtxt_pkg::REG_ALPHABET_HIGH: alpha_high_cfg = data;
      radtxt_pkg::REG_RADIX:         radix_cfg      = data[radtxt_pkg::RADIX_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [radtxt_pkg::CFG_BITS-1:0] low,
                           input logic [radtxt_pkg::CFG_BITS-1:0] high,
                           input logic [radtxt_pkg::CFG_BITS-1:0] radix_word);
    cfg_write(radtxt_pkg::REG_ALPHABET_LOW, low);
    cfg_write(radtxt_pkg::REG_ALPHABET_HIGH, high);
    cfg_write(radtxt_pkg::REG_RADIX, radix_word);
  endtask

  // Sixteen distinct random bytes, none of them a sign.
  function automatic logic [radtxt_pkg::ALPHA_BITS-1:0] random_alphabet();
    logic [radtxt_pkg::ALPHA_BITS-1:0] word;
    bit                                taken[256];
    int unsigned                       pick;
    word = '0;
    for (int k = 0; k < radtxt_pkg::MAX_SYMBOLS; k++) begin
      do pick = $urandom_range(0, 255);
      while (taken[pick] || pick == radtxt_pkg::SIGN_CHAR ||
             pick == radtxt_pkg::PLUS_CHAR);
      taken[pick] = 1'b1;
      word[k*radtxt_pkg::CHAR_BITS +: radtxt_pkg::CHAR_BITS] =
        radtxt_pkg::CHAR_BITS'(pick);
    end
    return word;
  endfunction

  // A number drawn to reach the interesting parts of the conversion: full
  // random words, short texts, the extremes, and the edges where the text
  // gains a digit in the current base.
  function automatic logic [radtxt_pkg::VALUE_BITS-1:0] pick_number();
    logic [radtxt_pkg::VALUE_BITS-1:0] power;
    int unsigned                       base;
    int                                steps;
    base = (radix_cfg < radtxt_pkg::MIN_RADIX) ? 10 : radix_cfg;
    case ($urandom_range(0, 5))
      0, 1: return radtxt_pkg::VALUE_BITS'($urandom());
      2: return radtxt_pkg::VALUE_BITS'($urandom_range(0, 300));
      3: return -radtxt_pkg::VALUE_BITS'($urandom_range(1, 300));
      4: begin
        case ($urandom_range(0, 3))
          0: return MOST_NEGATIVE;
          1: return MOST_POSITIVE;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        power = 1;
        steps = $urandom_range(1, radtxt_pkg::VALUE_BITS - 1);
        for (int k = 0; k < steps && power <= MOST_POSITIVE / base; k++) begin
          power = power * base;
        end
        power = power - $urandom_range(0, 1);
        return $urandom_range(0, 1) ? -power : power;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // After reset the radix is zero, so a number is taken and yields nothing.
  task automatic test_reset_state();
    send_number(32'd12345);
    wait_idle();
  endtask

  // Decimal digits: zero, one, minus one, a digit boundary and both extremes.
  task automatic test_decimal_extremes();
    configure(DIGITS_LOW, DIGITS_HIGH, 64'd10);
    send_number('0);
    send_number(32'd1);
    send_number('1);
    send_number(32'd9);
    send_number(-32'sd10);
    send_number(MOST_POSITIVE);
    send_number(MOST_NEGATIVE);
    wait_idle();
  endtask

  // Base sixteen, then base two, where the most negative number gives the
  // longest text of all: a sign and thirty-two digits. The radix word carries
  // set upper bits, which the block must ignore.
  task automatic test_radix_extremes();
    cfg_write(radtxt_pkg::REG_RADIX, 64'd16);
    send_number(MOST_NEGATIVE);
    send_number('1);
    wait_idle();
    cfg_write(radtxt_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE2);
    send_number(MOST_NEGATIVE);
    send_number(MOST_POSITIVE);
    send_number(32'h5555_5555);
    wait_idle();
  endtask

  // Each unusable alphabet swallows the number silently. The last setting
  // has a minus sign, but only beyond the radix, so it works.
  task automatic test_rejected_alphabets();
    cfg_write(radtxt_pkg::REG_RADIX, 64'd1);
    send_number(32'd7);
    wait_idle();
    cfg_write(radtxt_pkg::REG_RADIX, 64'd17);
    send_number(-32'sd7);
    wait_idle();
    cfg_write(radtxt_pkg::REG_RADIX, '1);
    send_number(32'd100);
    wait_idle();
    // A repeated symbol across the two words, then one within the high word.
    configure(DIGITS_LOW, 64'h4645444342413038, 64'd10);
    send_number(32'd99);
    wait_idle();
    configure(DIGITS_LOW, 64'h3845444342413938, 64'd16);
    send_number(32'd99);
    wait_idle();
    // A plus sign, then a minus sign, among the symbols in use.
    configure(64'h373635342B323130, DIGITS_HIGH, 64'd10);
    send_number(-32'sd5);
    wait_idle();
    configure(DIGITS_LOW, 64'h464544434241392D, 64'd16);
    send_number(-32'sd5);
    wait_idle();
    cfg_write(radtxt_pkg::REG_RADIX, 64'd8);
    send_number(-32'sd4095);
    wait_idle();
  endtask

  // A zero byte is a symbol like any other; the unused high word is all ones.
  task automatic test_zero_byte_symbol();
    configure(64'hFF06050403020100, '1, 64'd8);
    send_number('0);
    send_number(-32'sd8);
    send_number(MOST_NEGATIVE);
    wait_idle();
  endtask

  // Phases of random alphabets and bases. Most phases are usable alphabets;
  // the rest break the alphabet in one of its ways and send a few numbers.
  task automatic test_random_conversions(input int phases, input int per_phase);
    logic [radtxt_pkg::ALPHA_BITS-1:0] alphabet;
    logic [radtxt_pkg::CFG_BITS-1:0]   radix_word;
    int                                base;
    int                                a;
    int                                b;
    bit                                broken;
    for (int p = 0; p < phases; p++) begin
      alphabet = random_alphabet();
      base     = $urandom_range(2, radtxt_pkg::MAX_SYMBOLS);
      broken   = ($urandom_range(0, 5) == 0);
      if (broken) begin
        a = $urandom_range(0, base - 1);
        b = (a + $urandom_range(1, base - 1)) % base;
        case ($urandom_range(0, 3))
          0: base = $urandom_range(0, 1);
          1: base = $urandom_range(radtxt_pkg::MAX_SYMBOLS + 1, 31);
          2: alphabet[b*radtxt_pkg::CHAR_BITS +: radtxt_pkg::CHAR_BITS] =
               alphabet[a*radtxt_pkg::CHAR_BITS +: radtxt_pkg::CHAR_BITS];
          default: alphabet[a*radtxt_pkg::CHAR_BITS +: radtxt_pkg::CHAR_BITS] =
                     $urandom_range(0, 1) ? radtxt_pkg::SIGN_CHAR : radtxt_pkg::PLUS_CHAR;
        endcase
      end
      radix_word = {$urandom(), $urandom()};
      radix_word[radtxt_pkg::RADIX_BITS-1:0] = radtxt_pkg::RADIX_BITS'(base);
      if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, {$urandom(), $urandom()});
      configure(alphabet[radtxt_pkg::CFG_BITS-1:0],
                alphabet[radtxt_pkg::ALPHA_BITS-1:radtxt_pkg::CFG_BITS], radix_word);
      // Some phases run flat out on both sides.
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < (broken ? 5 : per_phase); n++) send_number(pick_number());
      wait_idle();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering numbers, so the block fills and stalls its input. Later the
  // sender stops until all text has come out before carrying on.
  task automatic test_backpressure();
    configure(DIGITS_LOW, DIGITS_HIGH, 64'd2);
    gaps_on      = 1'b0;
    hold_request = 400;
    for (int n = 0; n < 12; n++) send_number(pick_number());
    gaps_on = 1'b1;
    for (int n = 0; n < 10; n++) send_number(pick_number());
    wait_text_drained();
    for (int n = 0; n < 10; n++) send_number(pick_number());
    wait_idle();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_decimal_extremes();
    test_radix_extremes();
    test_rejected_alphabets();
    test_zero_byte_symbol();
    test_random_conversions(8, 35);
    test_backpressure();
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every number at full length with
  // every character waiting out the longest stall pattern.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/radtxt_pkg.sv
rtl/signed_int_to_custom_radix_text.sv
bench/tb_signed_int_to_custom_radix_text.sv
